// ===== hw/rtl/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// stencil csr row generator package
// shared widths, register codes, config and row descriptor types
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam int SIZE_W    = 7;
    localparam int POS_W     = 6;
    localparam int START_W   = 15;
    localparam int COL_W     = 12;
    localparam int COEF_W    = 32;
    localparam int VAL_W     = 34;
    localparam int CNT_W     = 3;
    localparam int IDX_W     = 3;
    localparam int TDATA_W   = 64;
    localparam int IN_DATA_W = 8;

    localparam int DEFAULT_ROW_STRIDE      = 64;
    localparam int DEFAULT_MAX_GRID_HEIGHT = 64;
    localparam int GRID_SIZE_MIN           = 2;
    localparam int GRID_SIZE_MAX           = 64;
    localparam int QUEUE_DEPTH             = 2;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = SIZE_W'(GRID_SIZE_MAX);

    localparam logic BOUNDARY_DIRICHLET = 1'b0;
    localparam logic BOUNDARY_NEUMANN   = 1'b1;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_WIDTH    = 3'd0,
        REG_GRID_HEIGHT   = 3'd1,
        REG_BOUNDARY_MODE = 3'd2,
        REG_COEF_SOUTH    = 3'd3,
        REG_COEF_WEST     = 3'd4,
        REG_COEF_CENTER   = 3'd5,
        REG_COEF_EAST     = 3'd6,
        REG_COEF_NORTH    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        grid_width;
        logic [SIZE_W-1:0]        grid_height;
        logic                     boundary_mode;
        logic signed [COEF_W-1:0] coef_south;
        logic signed [COEF_W-1:0] coef_west;
        logic signed [COEF_W-1:0] coef_center;
        logic signed [COEF_W-1:0] coef_east;
        logic signed [COEF_W-1:0] coef_north;
    } cfg_t;

    // one grid point, classified, on its way from front to back
    typedef struct packed {
        logic                    first_row;
        logic                    first_col;
        logic                    last_col;
        logic                    last_row;
        logic                    walk_end;
        logic [START_W-1:0]      row_start;
        logic [START_W-1:0]      end_count;
        logic [COL_W-1:0]        base;
        logic signed [VAL_W-1:0] part_a;
        logic signed [VAL_W-1:0] part_b;
    } desc_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(GRID_SIZE_MIN)) begin
            r = SIZE_W'(GRID_SIZE_MIN);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] sext_coef(input logic signed [COEF_W-1:0] c);
        return {{(VAL_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    // coefficient of a missing neighbour, signed by the boundary mode
    function automatic logic signed [VAL_W-1:0] fold_term(input logic signed [COEF_W-1:0] c,
                                                          input logic missing,
                                                          input logic mode);
        logic signed [VAL_W-1:0] ext;
        logic signed [VAL_W-1:0] r;
        ext = sext_coef(c);
        if (!missing) begin
            r = '0;
        end else if (mode == BOUNDARY_NEUMANN) begin
            r = ext;
        end else begin
            r = -ext;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/srg_cfg.sv =====
// ----------------------------------------------------------------------------
// srg_cfg
// configuration register file, one write per transfer on the config channel
// ----------------------------------------------------------------------------
module srg_cfg
    import srg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width    <= GRID_SIZE_RESET;
            cfg_reg.grid_height   <= GRID_SIZE_RESET;
            cfg_reg.boundary_mode <= BOUNDARY_DIRICHLET;
            cfg_reg.coef_south    <= '0;
            cfg_reg.coef_west     <= '0;
            cfg_reg.coef_center   <= '0;
            cfg_reg.coef_east     <= '0;
            cfg_reg.coef_north    <= '0;
        end else if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_GRID_WIDTH:    cfg_reg.grid_width    <= cfg_data[SIZE_W-1:0];
                REG_GRID_HEIGHT:   cfg_reg.grid_height   <= cfg_data[SIZE_W-1:0];
                REG_BOUNDARY_MODE: cfg_reg.boundary_mode <= cfg_data[0];
                REG_COEF_SOUTH:    cfg_reg.coef_south    <= cfg_data[COEF_W-1:0];
                REG_COEF_WEST:     cfg_reg.coef_west     <= cfg_data[COEF_W-1:0];
                REG_COEF_CENTER:   cfg_reg.coef_center   <= cfg_data[COEF_W-1:0];
                REG_COEF_EAST:     cfg_reg.coef_east     <= cfg_data[COEF_W-1:0];
                REG_COEF_NORTH:    cfg_reg.coef_north    <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/srg_front.sv =====
// ----------------------------------------------------------------------------
// srg_front
// walks the grid, classifies each point, folds south/west/east boundary terms
// ----------------------------------------------------------------------------
module srg_front
    import srg_pkg::*;
#(
    parameter int ROW_STRIDE      = DEFAULT_ROW_STRIDE,
    parameter int MAX_GRID_HEIGHT = DEFAULT_MAX_GRID_HEIGHT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  start_over,
    output logic  desc_valid,
    input  logic  desc_ready,
    output desc_t desc
);

    localparam int W_MAX_INT = (ROW_STRIDE < GRID_SIZE_MAX) ? ROW_STRIDE : GRID_SIZE_MAX;
    localparam int H_MAX_INT = (MAX_GRID_HEIGHT < GRID_SIZE_MAX) ? MAX_GRID_HEIGHT
                                                                 : GRID_SIZE_MAX;
    localparam logic [SIZE_W-1:0] W_MAX      = SIZE_W'(W_MAX_INT);
    localparam logic [SIZE_W-1:0] H_MAX      = SIZE_W'(H_MAX_INT);
    localparam logic [COL_W-1:0]  STRIDE_COL = COL_W'(ROW_STRIDE);

    logic [POS_W-1:0]   col_reg, row_reg;
    logic [START_W-1:0] count_reg;
    logic               done_reg;
    logic               valid_reg;
    desc_t              desc_reg;

    logic [SIZE_W-1:0]  w_last, h_last;
    logic [POS_W-1:0]   col_eff, row_eff;
    logic [START_W-1:0] count_eff, count_next;
    logic               done_eff;
    logic               accept;
    logic               first_row, first_col, last_col, last_row;
    logic [CNT_W-1:0]   n_entries;
    desc_t              desc_next;

    assign w_last = clamp_size(cfg.grid_width, W_MAX) - SIZE_W'(1);
    assign h_last = clamp_size(cfg.grid_height, H_MAX) - SIZE_W'(1);

    assign s_tready   = !valid_reg || desc_ready;
    assign accept     = s_tvalid && s_tready;
    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

    // restart takes effect before the point is classified
    assign col_eff   = start_over ? '0 : col_reg;
    assign row_eff   = start_over ? '0 : row_reg;
    assign count_eff = start_over ? '0 : count_reg;
    assign done_eff  = start_over ? 1'b0 : done_reg;

    assign first_row = (row_eff == '0);
    assign first_col = (col_eff == '0);
    assign last_row  = ({1'b0, row_eff} >= h_last);
    assign last_col  = ({1'b0, col_eff} >= w_last);

    assign n_entries = CNT_W'(1) + CNT_W'(!first_row) + CNT_W'(!first_col)
                     + CNT_W'(!last_col) + CNT_W'(!last_row);
    assign count_next = count_eff + START_W'(n_entries);

    always_comb begin
        desc_next.first_row = first_row;
        desc_next.first_col = first_col;
        desc_next.last_col  = last_col;
        desc_next.last_row  = last_row;
        desc_next.walk_end  = last_col && last_row;
        desc_next.row_start = count_eff;
        desc_next.end_count = count_next;
        desc_next.base      = COL_W'(row_eff) * STRIDE_COL + COL_W'(col_eff);
        desc_next.part_a    = sext_coef(cfg.coef_center)
                            + fold_term(cfg.coef_south, first_row, cfg.boundary_mode);
        desc_next.part_b    = fold_term(cfg.coef_west, first_col, cfg.boundary_mode)
                            + fold_term(cfg.coef_east, last_col, cfg.boundary_mode);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (accept && !done_eff) begin
                valid_reg <= 1'b1;
                count_reg <= count_next;
                if (last_col) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg  <= row_eff;
                        done_reg <= 1'b1;
                    end else begin
                        row_reg  <= row_eff + POS_W'(1);
                        done_reg <= 1'b0;
                    end
                end else begin
                    col_reg  <= col_eff + POS_W'(1);
                    row_reg  <= row_eff;
                    done_reg <= 1'b0;
                end
            end else if (desc_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !done_eff) begin
            desc_reg <= desc_next;
        end
    end

endmodule

// ===== hw/rtl/srg_queue.sv =====
// ----------------------------------------------------------------------------
// srg_queue
// short descriptor queue between front and back
// ----------------------------------------------------------------------------
module srg_queue
    import srg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output desc_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    desc_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_QW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_QW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_QW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) && !push |=> !pop_valid)
        else $error("queue shows data that was never pushed");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + CNT_QW'(1))
        else $error("queue count missed a push");

endmodule

// ===== hw/rtl/srg_back.sv =====
// ----------------------------------------------------------------------------
// srg_back
// expands a descriptor into nonzeros (end pointer if last), one per free cycle
// ----------------------------------------------------------------------------
module srg_back
    import srg_pkg::*;
#(
    parameter int ROW_STRIDE = DEFAULT_ROW_STRIDE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               desc_valid,
    output logic               desc_ready,
    input  desc_t              desc,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam logic [COL_W-1:0] STRIDE_COL = COL_W'(ROW_STRIDE);
    localparam int NUM_SLOTS = 6;
    localparam int PAD_W     = TDATA_W - VAL_W - COL_W - START_W;

    typedef enum logic [2:0] {
        SLOT_SOUTH  = 3'd0,
        SLOT_WEST   = 3'd1,
        SLOT_CENTER = 3'd2,
        SLOT_EAST   = 3'd3,
        SLOT_NORTH  = 3'd4,
        SLOT_END    = 3'd5
    } slot_t;

    logic                    cur_valid_reg;
    logic [NUM_SLOTS-1:0]    mask_reg;
    desc_t                   cur_reg;
    logic signed [VAL_W-1:0] diag_ab_reg;

    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic                    out_last_reg;
    logic [START_W-1:0]      out_start_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic signed [VAL_W-1:0] out_val_reg;

    slot_t                   slot_idx;
    logic [NUM_SLOTS-1:0]    sel, mask_left, mask_load;
    logic                    out_free, emit, cur_done, load;
    logic                    kind_next;
    logic [START_W-1:0]      start_next;
    logic [COL_W-1:0]        col_next;
    logic signed [VAL_W-1:0] val_next;

    // lowest pending slot goes first
    always_comb begin
        slot_idx = SLOT_SOUTH;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                slot_idx = slot_t'(3'(i));
            end
        end
    end

    assign sel       = NUM_SLOTS'(1) << slot_idx;
    assign mask_left = mask_reg & ~sel;
    assign cur_done  = (mask_left == '0);
    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = cur_valid_reg && out_free;
    assign desc_ready = !cur_valid_reg || (emit && cur_done);
    assign load      = desc_valid && desc_ready;

    assign mask_load = {desc.walk_end, !desc.last_row, !desc.last_col, 1'b1,
                        !desc.first_col, !desc.first_row};

    always_comb begin
        kind_next  = KIND_ENTRY;
        start_next = cur_reg.row_start;
        col_next   = cur_reg.base;
        val_next   = '0;
        unique case (slot_idx)
            SLOT_SOUTH: begin
                col_next = cur_reg.base - STRIDE_COL;
                val_next = sext_coef(cfg.coef_south);
            end
            SLOT_WEST: begin
                col_next = cur_reg.base - COL_W'(1);
                val_next = sext_coef(cfg.coef_west);
            end
            SLOT_CENTER: begin
                val_next = diag_ab_reg
                         + fold_term(cfg.coef_north, cur_reg.last_row, cfg.boundary_mode);
            end
            SLOT_EAST: begin
                col_next = cur_reg.base + COL_W'(1);
                val_next = sext_coef(cfg.coef_east);
            end
            SLOT_NORTH: begin
                col_next = cur_reg.base + STRIDE_COL;
                val_next = sext_coef(cfg.coef_north);
            end
            SLOT_END: begin
                kind_next  = KIND_END;
                start_next = cur_reg.end_count;
                col_next   = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                cur_valid_reg <= 1'b1;
                mask_reg      <= mask_load;
            end else if (emit) begin
                mask_reg <= mask_left;
                if (cur_done) begin
                    cur_valid_reg <= 1'b0;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg     <= desc;
            diag_ab_reg <= desc.part_a + desc.part_b;
        end
        if (emit) begin
            out_kind_reg  <= kind_next;
            out_last_reg  <= cur_done;
            out_start_reg <= start_next;
            out_col_reg   <= col_next;
            out_val_reg   <= val_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_val_reg, out_col_reg, out_start_reg};

    a_mask_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> mask_reg != '0)
        else $error("active row has no pending result");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_kind_reg == KIND_END) |-> out_last_reg)
        else $error("end pointer not marked last");

    a_end_only_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg && mask_reg[SLOT_END] |-> cur_reg.last_row && cur_reg.last_col)
        else $error("end pointer pending away from the last point");

endmodule

// ===== hw/rtl/stencil_csr_row_generator_top.sv =====
// ----------------------------------------------------------------------------
// stencil_csr_row_generator_top
// five-point stencil matrix rows in compressed-sparse-row form, one grid
// point per input transfer, raster order, boundary terms folded into the
// diagonal
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// s_        in         s_tvalid / s_tready     s_tdata[0] start_over
// m_        out        m_tvalid / m_tready     m_tdata row_start, column,
//                                              entry_value; m_tuser kind;
//                                              m_tlast last
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one result leaves per cycle from the output register while m_tready is high;
// a grid point has 3 to 5 nonzeros, plus the end pointer at the last point,
// all emitted by the expansion step in the back end
// an input transfer reaches the output through the front register, queue,
// row cursor and output register
// aresetn is synchronous, active low; it returns the config registers to
// width 64, height 64, Dirichlet, zero coefficients and restarts the walk
// the front keeps taking points while results wait on m_tready, until the
// two-entry queue and the front register are full
// config writes take effect at once and are meant for idle periods only
//
module stencil_csr_row_generator_top
    import srg_pkg::*;
#(
    parameter int ROW_STRIDE      = DEFAULT_ROW_STRIDE,
    parameter int MAX_GRID_HEIGHT = DEFAULT_MAX_GRID_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // input transfers, one per grid point
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // [0] start_over, [7:1] zero

    // result transfers
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [14:0] row_start, [26:15] column,
                                            // [60:27] entry_value, [63:61] zero
    output logic                 m_tuser,   // [0] kind
    output logic                 m_tlast,

    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t  cfg;

    // front to queue
    logic  fq_valid, fq_ready;
    desc_t fq_desc;

    // queue to back
    logic  qb_valid, qb_ready;
    desc_t qb_desc;

    // register file, written on each config transfer
    srg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // front: grid walk, classification, partial diagonal sums
    srg_front #(
        .ROW_STRIDE      (ROW_STRIDE),
        .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .start_over (s_tdata[0]),
        .desc_valid (fq_valid),
        .desc_ready (fq_ready),
        .desc       (fq_desc)
    );

    // decouples the walk from the result stream
    srg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_desc),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_desc)
    );

    // back: one nonzero or end pointer per free cycle into the output register
    srg_back #(
        .ROW_STRIDE (ROW_STRIDE)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .desc_valid (qb_valid),
        .desc_ready (qb_ready),
        .desc       (qb_desc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== dv/stencil_csr_row_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_csr_row_generator_top_tb
// self-checking bench: grid points stream in under random bursts and gaps,
// results drain under random back-pressure, and every result is compared
// field by field against a row predictor kept in step with the register file
// ----------------------------------------------------------------------------
module stencil_csr_row_generator_top_tb;
    import srg_pkg::*;

    localparam int ROW_STRIDE      = DEFAULT_ROW_STRIDE;
    localparam int MAX_GRID_HEIGHT = DEFAULT_MAX_GRID_HEIGHT;
    localparam int IDLE_LIMIT      = 2000;   // cycles with no transfer at all
    localparam int SETTLE_CYCLES   = 20;     // drain pause before config and at the end
    localparam int RANDOM_POINTS   = 240;

    // one expected result transfer
    typedef struct {
        logic                kind;
        logic [START_W-1:0]  row_start;
        logic [COL_W-1:0]    column;
        logic [VAL_W-1:0]    value;
        logic                last;
    } csr_entry_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;   // [0] start_over
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // [14:0] row_start, [26:15] column,
                                            // [60:27] entry_value
    logic                 m_tuser;          // [0] kind
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // start_over flags waiting to be sent, one per grid point advance
    bit                   point_queue[$];
    csr_entry_t           csr_entries_exp[$];
    int                   fail_count = 0;

    // register mirror, reset values
    logic [SIZE_W-1:0]        grid_w   = SIZE_W'(GRID_SIZE_MAX);
    logic [SIZE_W-1:0]        grid_h   = SIZE_W'(GRID_SIZE_MAX);
    logic                     bnd_mode = BOUNDARY_DIRICHLET;
    logic signed [COEF_W-1:0] coef [5] = '{default: '0};   // south west center east north

    // walk state
    int unsigned              walk_col      = 0;
    int unsigned              walk_row      = 0;
    logic [START_W-1:0]       nnz_total     = '0;
    bit                       walk_finished = 1'b0;
    int                       entries_left;

    stencil_csr_row_generator_top #(
        .ROW_STRIDE     (ROW_STRIDE),
        .MAX_GRID_HEIGHT(MAX_GRID_HEIGHT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // row predictor
    // ------------------------------------------------------------------------

    // grid size as the block sees it: saturated to 2..hi, hi capped at 64
    function automatic int unsigned sat_size(input logic [SIZE_W-1:0] v, input int hi);
        int unsigned lim;
        lim = (hi < GRID_SIZE_MAX) ? hi : GRID_SIZE_MAX;
        if (v < GRID_SIZE_MIN) return GRID_SIZE_MIN;
        if (v > lim) return lim;
        return 32'(v);
    endfunction

    function automatic void add_entry(input logic kind, input logic [START_W-1:0] start,
                                      input int unsigned col, input longint val);
        csr_entry_t e;
        e.kind      = kind;
        e.row_start = start;
        e.column    = COL_W'(col);
        e.value     = VAL_W'(val);
        entries_left--;
        e.last      = (entries_left == 0);
        csr_entries_exp.push_back(e);
    endfunction

    // expected transfers for one grid point advance
    function automatic void predict_csr_row(input logic restart);
        int unsigned        w, h, base;
        longint             sgn, diag;
        logic [START_W-1:0] start;
        bit                 fr, fc, lc, lr;
        w   = sat_size(grid_w, ROW_STRIDE);
        h   = sat_size(grid_h, MAX_GRID_HEIGHT);
        sgn = (bnd_mode == BOUNDARY_NEUMANN) ? longint'(1) : longint'(-1);
        if (restart) begin
            walk_col      = 0;
            walk_row      = 0;
            nnz_total     = '0;
            walk_finished = 1'b0;
        end
        if (walk_finished) return;

        // a position left beyond a shrunken grid counts as the last column / row
        fr    = (walk_row == 0);
        fc    = (walk_col == 0);
        lc    = (walk_col >= w - 1);
        lr    = (walk_row >= h - 1);
        base  = walk_row * ROW_STRIDE + walk_col;
        start = nnz_total;
        entries_left = 1 + int'(!fr) + int'(!fc) + int'(!lc) + int'(!lr) + int'(lc && lr);

        diag = longint'(coef[2]);
        if (fr) diag += sgn * longint'(coef[0]);
        if (fc) diag += sgn * longint'(coef[1]);
        if (lc) diag += sgn * longint'(coef[3]);
        if (lr) diag += sgn * longint'(coef[4]);

        if (!fr) add_entry(KIND_ENTRY, start, base - ROW_STRIDE, longint'(coef[0]));
        if (!fc) add_entry(KIND_ENTRY, start, base - 1, longint'(coef[1]));
        add_entry(KIND_ENTRY, start, base, diag);
        if (!lc) add_entry(KIND_ENTRY, start, base + 1, longint'(coef[3]));
        if (!lr) add_entry(KIND_ENTRY, start, base + ROW_STRIDE, longint'(coef[4]));

        nnz_total = nnz_total + START_W'(1 + int'(!fr) + int'(!fc) + int'(!lc) + int'(!lr));

        if (lc) begin
            walk_col = 0;
            if (lr) begin
                walk_finished = 1'b1;
                add_entry(KIND_END, nnz_total, 0, longint'(0));
            end else begin
                walk_row = (walk_row + 1) % 64;
            end
        end else begin
            walk_col = (walk_col + 1) % 64;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (point_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_DATA_W'(point_queue.pop_front());
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    // now and then a long run with no gaps at all
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result back-pressure: ready runs, short stalls and long stalls
    // ------------------------------------------------------------------------
    int ready_hold = 0;
    int ready_pick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            ready_pick = $urandom_range(0, 9);
            if (ready_pick < 5) begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(1, 40);
            end else if (ready_pick < 8) begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(8, 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on each input transfer, check each result transfer
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        csr_entry_t want;
        if (aresetn) begin
            // input side first, the block cannot answer in the same cycle
            if (s_tvalid && s_tready) predict_csr_row(s_tdata[0]);
            if (m_tvalid && m_tready) begin
                if (csr_entries_exp.size() == 0) begin
                    $error("unexpected result transfer: tdata 0x%0h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = csr_entries_exp.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_tuser));
                    check_field("row_start", 64'(want.row_start),
                                64'(m_tdata[START_W-1:0]));
                    check_field("column", 64'(want.column), 64'(m_tdata[START_W +: COL_W]));
                    check_field("entry_value", 64'(want.value),
                                64'(m_tdata[START_W+COL_W +: VAL_W]));
                    check_field("last", 64'(want.last), 64'(m_tlast));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // register writes and phase control
    // ------------------------------------------------------------------------
    task automatic cfg_write(input reg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GRID_WIDTH:    grid_w   = data[SIZE_W-1:0];
            REG_GRID_HEIGHT:   grid_h   = data[SIZE_W-1:0];
            REG_BOUNDARY_MODE: bnd_mode = data[0];
            default:           coef[idx - REG_COEF_SOUTH] = data;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] w_data, input logic [31:0] h_data,
                                input logic [31:0] mode_data,
                                input logic [31:0] cs, input logic [31:0] cw,
                                input logic [31:0] cc, input logic [31:0] ce,
                                input logic [31:0] cn);
        cfg_write(REG_GRID_WIDTH, w_data);
        cfg_write(REG_GRID_HEIGHT, h_data);
        cfg_write(REG_BOUNDARY_MODE, mode_data);
        cfg_write(REG_COEF_SOUTH, cs);
        cfg_write(REG_COEF_WEST, cw);
        cfg_write(REG_COEF_CENTER, cc);
        cfg_write(REG_COEF_EAST, ce);
        cfg_write(REG_COEF_NORTH, cn);
        cfg_valid <= 1'b0;
    endtask

    // everything sent, every result back, then a pause for points that emit nothing
    task automatic wait_idle();
        do @(posedge aclk);
        while (point_queue.size() != 0 || s_tvalid || csr_entries_exp.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // occasional junk above the implemented bits of a narrow register
    function automatic logic [31:0] with_junk(input logic [31:0] v, input logic [31:0] keep);
        return ($urandom_range(0, 5) == 0) ? (v | ($urandom() & ~keep)) : v;
    endfunction

    initial begin : stimulus
        logic [SIZE_W-1:0] w, h;
        int unsigned       n_points;
        int                sent;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: 64x64 grid, all-zero coefficients
        repeat (3) point_queue.push_back(1'b0);
        wait_idle();

        // the walk sits at column 3, beyond a 3-wide grid: treated as last column
        apply_config(3, 64, 32'(BOUNDARY_DIRICHLET), 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        repeat (2) point_queue.push_back(1'b0);
        wait_idle();

        // row 1 becomes the last row; finish the walk, then two advances that emit nothing
        apply_config(3, 2, 32'(BOUNDARY_NEUMANN), 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        repeat (4) point_queue.push_back(1'b0);
        wait_idle();

        // smallest grid, all coefficients at the top, restart after the walk is done
        apply_config(2, 2, 32'(BOUNDARY_NEUMANN), 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        point_queue.push_back(1'b1);
        repeat (4) point_queue.push_back(1'b0);
        point_queue.push_back(1'b1);
        wait_idle();

        // sizes below range saturate up to 2
        apply_config(0, 1, 32'(BOUNDARY_DIRICHLET), 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        point_queue.push_back(1'b1);
        repeat (3) point_queue.push_back(1'b0);
        wait_idle();

        // sizes above range saturate down to 64
        apply_config(127, 127, 32'(BOUNDARY_DIRICHLET), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), rand_coef());
        point_queue.push_back(1'b1);
        point_queue.push_back(1'b0);

        // random walks, mostly small grids and whole walks from a restart
        sent = 0;
        while (sent < RANDOM_POINTS) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: begin
                    // long thin grids at the size extremes
                    if ($urandom_range(0, 1) != 0) begin
                        w = SIZE_W'(64);
                        h = SIZE_W'(2);
                    end else begin
                        w = SIZE_W'(2);
                        h = SIZE_W'(64);
                    end
                end
                1: begin
                    // out of range, kept to at most one 64-wide side
                    w = ($urandom_range(0, 1) != 0) ? SIZE_W'($urandom_range(65, 127))
                                                    : SIZE_W'($urandom_range(0, 1));
                    h = SIZE_W'($urandom_range(0, 1));
                end
                2: begin
                    w = SIZE_W'($urandom_range(2, 16));
                    h = SIZE_W'($urandom_range(2, 4));
                end
                default: begin
                    w = SIZE_W'($urandom_range(2, 6));
                    h = SIZE_W'($urandom_range(2, 6));
                end
            endcase
            apply_config(with_junk(32'(w), 32'h7f), with_junk(32'(h), 32'h7f),
                         with_junk($urandom_range(0, 1), 32'h1),
                         rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
            n_points = sat_size(w, ROW_STRIDE) * sat_size(h, MAX_GRID_HEIGHT);
            for (int k = 0; k < n_points; k++) begin
                // mostly a clean walk; sometimes carry on from the old position,
                // sometimes restart in the middle
                if (k == 0) point_queue.push_back($urandom_range(0, 5) != 0);
                else        point_queue.push_back($urandom_range(0, 40) == 0);
            end
            repeat ($urandom_range(0, 2)) point_queue.push_back(1'b0);
            sent += n_points;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/srg_pkg.sv
hw/rtl/srg_cfg.sv
hw/rtl/srg_front.sv
hw/rtl/srg_queue.sv
hw/rtl/srg_back.sv
hw/rtl/stencil_csr_row_generator_top.sv
dv/stencil_csr_row_generator_top_tb.sv
